// File: hdl/assert_macros.svh
// Assertion macros shared by the point-in-polygon RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define PIP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PIP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pip_pkg.sv
// Shared types and constants for the point-in-polygon block.
// No dependencies; imported by every module of the block.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int X_W     = 32;
    localparam int Y_W     = 31;
    localparam int TOTAL_W = 7;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // request function codes
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAT = 2'd3;

    typedef struct packed {
        logic signed [Y_W-1:0] y;
        logic signed [X_W-1:0] x;
    } vertex_t;

    // tags that travel with each vertex read
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } edge_ctl_t;

endpackage

// File: hdl/pip_vtx_mem.sv
// Vertex table: single-port-write, single-port-read synchronous RAM.
// Depends on pip_pkg (vertex_t, depth constants).
module pip_vtx_mem
    import pip_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  vertex_t           wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output vertex_t           rd_data
);

    vertex_t mem [MAX_VERTICES];
    vertex_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/pip_edge_eval.sv
// Three-stage edge crossing pipeline with parity accumulator.
// Depends on pip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pip_edge_eval
    import pip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [X_W-1:0] qx,
    input  logic signed [Y_W-1:0] qy,
    input  edge_ctl_t             ctl_in,
    input  vertex_t               vtx,
    output logic                  done,
    output logic                  parity
);

    vertex_t prev_reg;

    // stage A: classify edge, form differences
    logic signed [X_W-1:0] leftx, rightx, bx, tx;
    logic signed [Y_W-1:0] by, ty;
    logic                  edge_ok, direct;
    logic signed [X_W:0]   dx0, dxe;
    logic signed [Y_W:0]   dy0, dye;

    always_comb
    begin
        if (vtx.x < prev_reg.x)
        begin
            leftx  = vtx.x;
            rightx = prev_reg.x;
        end
        else
        begin
            leftx  = prev_reg.x;
            rightx = vtx.x;
        end
        if (vtx.y < prev_reg.y)
        begin
            bx = vtx.x;      by = vtx.y;
            tx = prev_reg.x; ty = prev_reg.y;
        end
        else
        begin
            bx = prev_reg.x; by = prev_reg.y;
            tx = vtx.x;      ty = vtx.y;
        end
        edge_ok = (vtx.y != prev_reg.y) && (qx < rightx) && (qy >= by) && (qy < ty);
        direct  = qx < leftx;
        dx0 = $signed({qx[X_W-1], qx}) - $signed({bx[X_W-1], bx});
        dxe = $signed({tx[X_W-1], tx}) - $signed({bx[X_W-1], bx});
        dy0 = $signed({qy[Y_W-1], qy}) - $signed({by[Y_W-1], by});
        dye = $signed({ty[Y_W-1], ty}) - $signed({by[Y_W-1], by});
    end

    // stage 1 registers
    edge_ctl_t             s1_ctl_reg;
    logic                  s1_ok_reg, s1_direct_reg;
    logic signed [X_W:0]   s1_dx0_reg, s1_dxe_reg;
    logic signed [Y_W:0]   s1_dy0_reg, s1_dye_reg;

    // stage 2 registers: cross products
    localparam int P_W = X_W + Y_W + 2;
    edge_ctl_t             s2_ctl_reg;
    logic                  s2_ok_reg, s2_direct_reg;
    logic signed [P_W-1:0] s2_lhs_reg, s2_rhs_reg;

    logic parity_reg, parity_next;
    logic done_reg;
    logic hit;

    always_ff @(posedge clk)
    begin
        if (ctl_in.vld)
        begin
            prev_reg <= vtx;
        end
        s1_ok_reg     <= edge_ok;
        s1_direct_reg <= direct;
        s1_dx0_reg    <= dx0;
        s1_dxe_reg    <= dxe;
        s1_dy0_reg    <= dy0;
        s1_dye_reg    <= dye;
        s2_ok_reg     <= s1_ok_reg;
        s2_direct_reg <= s1_direct_reg;
        s2_lhs_reg    <= P_W'(s1_dx0_reg) * P_W'(s1_dye_reg);
        s2_rhs_reg    <= P_W'(s1_dy0_reg) * P_W'(s1_dxe_reg);
    end

    // the closing-vertex read only primes prev_reg, it is not an edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            parity_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_ctl_reg.vld   <= ctl_in.vld && !ctl_in.first;
            s1_ctl_reg.first <= 1'b0;
            s1_ctl_reg.last  <= ctl_in.vld && ctl_in.last;
            s2_ctl_reg       <= s1_ctl_reg;
            parity_reg       <= parity_next;
            done_reg         <= s2_ctl_reg.last;
        end
    end

    always_comb
    begin
        hit = s2_ctl_reg.vld && s2_ok_reg && (s2_direct_reg || (s2_lhs_reg < s2_rhs_reg));
        if (start)
        begin
            parity_next = 1'b0;
        end
        else
        begin
            parity_next = parity_reg ^ hit;
        end
    end

    assign done   = done_reg;
    assign parity = parity_reg;

    `PIP_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "done held two cycles")
    `PIP_ASSERT_NEXT(a_prime_no_edge, clk, rst_n, ctl_in.vld && ctl_in.first, !s1_ctl_reg.vld,
        "priming read treated as edge")
    `PIP_ASSERT_SAME(a_last_valid, clk, rst_n, ctl_in.last, ctl_in.vld, "last tag without data")

endmodule

// File: hdl/point_in_polygon_test.sv
// Clear, append and unused codes go straight to the pending result; a query first walks the table.
// Throughput: one request at a time; a query reads the closing vertex and then every vertex
// of the table, and each edge passes through the 3-stage crossing pipeline.
// A new request is taken while the previous result still waits at the output.
// Reset (async, active low) empties the table and loads the full-globe box;
// the vertex RAM itself is not cleared.
//
// Top level: request sequencer, box check, configuration and result registers.
// Depends on pip_pkg, pip_vtx_mem, pip_edge_eval and assert_macros.svh.
`include "assert_macros.svh"

module point_in_polygon_test
    import pip_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_idx,
    input  logic [CFG_W-1:0]         cfg_data,
    // request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               func,
    input  logic signed [X_W-1:0]    coord_x,
    input  logic signed [Y_W-1:0]    coord_y,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     inside_res,
    output logic                     in_box,
    output logic [1:0]               status,
    output logic [TOTAL_W-1:0]       vertex_total
);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a request
    localparam logic [1:0] S_WALK  = 2'd1;  // issuing vertex reads
    localparam logic [1:0] S_DRAIN = 2'd2;  // crossing pipeline emptying
    localparam logic [1:0] S_HOLD  = 2'd3;  // result pending for output reg

    logic [1:0] state_reg, state_next;

    // bounding box registers
    logic signed [X_W-1:0] min_lon_reg, max_lon_reg;
    logic signed [Y_W-1:0] min_lat_reg, max_lat_reg;

    // table fill count and walk counter
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] walk_reg, walk_next;

    // latched query point
    logic signed [X_W-1:0] qx_reg;
    logic signed [Y_W-1:0] qy_reg;

    // pending result
    logic       pend_inside_reg, pend_inside_next;
    logic       pend_box_reg, pend_box_next;
    logic [1:0] pend_status_reg, pend_status_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_inside_reg, out_box_reg;
    logic [1:0]         out_status_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_load;

    // RAM and pipeline hookup
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    vertex_t           rd_data;
    vertex_t           wr_vtx;
    edge_ctl_t         rd_ctl_reg, rd_ctl_next;
    logic              edge_start;
    logic              edge_done;
    logic              edge_parity;

    logic accept;
    logic box_hit;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // limits inclusive; an inverted box simply never matches
    assign box_hit = (coord_x >= min_lon_reg) && (coord_x <= max_lon_reg)
                  && (coord_y >= min_lat_reg) && (coord_y <= max_lat_reg);

    assign wr_vtx.x = coord_x;
    assign wr_vtx.y = coord_y;

    // output register frees up when empty or being taken this cycle
    assign out_load = (state_reg == S_HOLD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        walk_next        = walk_reg;
        pend_inside_next = pend_inside_reg;
        pend_box_next    = pend_box_reg;
        pend_status_next = pend_status_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        rd_ctl_next      = '0;
        edge_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_inside_next = 1'b0;
                    pend_box_next    = 1'b0;
                    pend_status_next = STAT_OK;
                    state_next       = S_HOLD;
                    case (func)
                        FUNC_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        FUNC_APPEND:
                        begin
                            if (cnt_reg < CNT_W'(MAX_VERTICES))
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                pend_status_next = STAT_FULL;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            pend_box_next = box_hit;
                            if (cnt_reg == '0)
                            begin
                                pend_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                edge_start = 1'b1;
                                walk_next  = '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            // unused code: the vertex table and count are left unchanged
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // first read fetches the closing vertex, then 0 .. n-1
                rd_en = 1'b1;
                if (walk_reg == '0)
                begin
                    rd_addr = ADDR_W'(cnt_reg - 1'b1);
                end
                else
                begin
                    rd_addr = ADDR_W'(walk_reg - 1'b1);
                end
                rd_ctl_next.vld   = 1'b1;
                rd_ctl_next.first = (walk_reg == '0);
                rd_ctl_next.last  = (walk_reg == cnt_reg);
                walk_next = walk_reg + 1'b1;
                if (walk_reg == cnt_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (edge_done)
                begin
                    pend_inside_next = edge_parity;
                    state_next       = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            walk_reg      <= '0;
            rd_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
            min_lon_reg   <= -X_W'(1800000000);
            max_lon_reg   <= X_W'(1800000000);
            min_lat_reg   <= -Y_W'(900000000);
            max_lat_reg   <= Y_W'(900000000);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            walk_reg      <= walk_next;
            rd_ctl_reg    <= rd_ctl_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_MIN_LON: min_lon_reg <= cfg_data[X_W-1:0];
                    CFG_MAX_LON: max_lon_reg <= cfg_data[X_W-1:0];
                    CFG_MIN_LAT: min_lat_reg <= cfg_data[Y_W-1:0];
                    CFG_MAX_LAT: max_lat_reg <= cfg_data[Y_W-1:0];
                    default:
                    begin
                        // no other registers
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_inside_reg <= pend_inside_next;
        pend_box_reg    <= pend_box_next;
        pend_status_reg <= pend_status_next;
        if (accept)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
        end
        if (out_load)
        begin
            out_inside_reg <= pend_inside_reg;
            out_box_reg    <= pend_box_reg;
            out_status_reg <= pend_status_reg;
            out_total_reg  <= TOTAL_W'(cnt_reg);
        end
    end

    pip_vtx_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (wr_vtx),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pip_edge_eval u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (edge_start),
        .qx     (qx_reg),
        .qy     (qy_reg),
        .ctl_in (rd_ctl_reg),
        .vtx    (rd_data),
        .done   (edge_done),
        .parity (edge_parity)
    );

    assign out_valid    = out_valid_reg;
    assign inside_res   = out_inside_reg;
    assign in_box       = out_box_reg;
    assign status       = out_status_reg;
    assign vertex_total = out_total_reg;

    `PIP_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(MAX_VERTICES),
        "vertex count beyond table size")
    `PIP_ASSERT_SAME(a_done_in_query, clk, rst_n, edge_done,
        state_reg == S_DRAIN, "edge walk finished outside a query")
    `PIP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept,
        state_reg == S_WALK || state_reg == S_HOLD, "request accepted but sequencer idle")
    `PIP_ASSERT_SAME(a_no_write_in_walk, clk, rst_n, rd_en, !wr_en,
        "table written during a walk")

endmodule
